// ===== src/scaled_color_key_sprite_blit_top_assert.svh =====
// Assertion macros for the scaled color key sprite blitter.
// Used by modules that have clk and rst_n in scope.
`ifndef SCALED_COLOR_KEY_SPRITE_BLIT_TOP_ASSERT_SVH
`define SCALED_COLOR_KEY_SPRITE_BLIT_TOP_ASSERT_SVH

// check a same-cycle implication
`define SCKB_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// check an implication in the next cycle
`define SCKB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== src/sckb_pkg.sv =====
// Shared types and constants of the scaled color key sprite blitter.
// No dependencies.
package sckb_pkg;

  localparam int COL_W      = 10;
  localparam int COLOR_W    = 16;
  localparam int COORD_W    = 16;
  localparam int PIX_W      = 17;
  localparam int SCALE_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR   = 3'd7;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd1;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] clip_left;
    logic signed [COORD_W-1:0] clip_top;
    logic signed [COORD_W-1:0] clip_right;
    logic signed [COORD_W-1:0] clip_bottom;
    logic [SCALE_W-1:0]        scale;
    logic [COLOR_W-1:0]        key_color;
  } sckb_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0]   bx;
    logic [PIX_W-1:0]   by;
    logic [COLOR_W-1:0] color;
    logic [SCALE_W-1:0] s;
  } sckb_job_t;

endpackage

// ===== src/sckb_front.sv =====
// Front end: accepts texel requests, drops zero-scale, keyed, out-of-bitmap and clipped
// texels, and hands visible blocks to the job queue. Depends on sckb_pkg.
module sckb_front
  import sckb_pkg::*;
#(
  parameter int MAX_BITMAP_SIDE = 1024,
  parameter int MAX_SCALE       = 8
) (
  input  sckb_cfg_t          cfg,
  input  logic               in_push,
  input  logic [COL_W-1:0]   in_col,
  input  logic [COL_W-1:0]   in_row,
  input  logic [COLOR_W-1:0] in_color,
  input  logic               q_full,
  output logic               in_full,
  output logic               q_push,
  output sckb_job_t          q_data
);

  localparam int SIDE_W = $clog2(MAX_BITMAP_SIDE + 1);
  localparam int CMP_W  = (SIDE_W > COL_W) ? SIDE_W : COL_W;
  localparam int PROD_W = COL_W + SCALE_W;

  logic [SCALE_W-1:0]     s_sat;
  logic [PROD_W-1:0]      prod_x, prod_y;
  logic signed [PIX_W-1:0] bx, by, bx_end, by_end;
  logic signed [PIX_W-1:0] cl, ct, cr, cb;
  logic                   col_ok, row_ok, visible;

  always_comb begin
    s_sat  = (cfg.scale > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : cfg.scale;
    prod_x = PROD_W'(in_col) * PROD_W'(s_sat);
    prod_y = PROD_W'(in_row) * PROD_W'(s_sat);
    bx     = PIX_W'(cfg.origin_x) + $signed(PIX_W'(prod_x));
    by     = PIX_W'(cfg.origin_y) + $signed(PIX_W'(prod_y));
    bx_end = bx + $signed(PIX_W'(s_sat));
    by_end = by + $signed(PIX_W'(s_sat));
    cl     = PIX_W'(cfg.clip_left);
    ct     = PIX_W'(cfg.clip_top);
    cr     = PIX_W'(cfg.clip_right);
    cb     = PIX_W'(cfg.clip_bottom);
    col_ok = CMP_W'(in_col) < CMP_W'(MAX_BITMAP_SIDE);
    row_ok = CMP_W'(in_row) < CMP_W'(MAX_BITMAP_SIDE);
    visible = (s_sat != '0) && (in_color != cfg.key_color) && col_ok && row_ok &&
              (bx < cr) && (bx_end > cl) && (by < cb) && (by_end > ct);
  end

  assign in_full      = q_full;
  assign q_push       = in_push && !q_full && visible;
  assign q_data.bx    = bx;
  assign q_data.by    = by;
  assign q_data.color = in_color;
  assign q_data.s     = s_sat;

endmodule

// ===== src/sckb_queue.sv =====
// Short job queue between front end and pixel expander, in flip-flops.
// Depends on sckb_pkg and the assertion macro header.
`include "scaled_color_key_sprite_blit_top_assert.svh"
module sckb_queue
  import sckb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  sckb_job_t push_data,
  input  logic      pop,
  output logic      full,
  output logic      valid,
  output sckb_job_t pop_data
);

  sckb_job_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign full     = count_r == QCNT_W'(QUEUE_DEPTH);
  assign valid    = count_r != '0;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `SCKB_ASSERT_IMPLIES(a_no_overflow, push, !full)
  `SCKB_ASSERT_IMPLIES(a_no_underflow, pop, valid)

endmodule

// ===== src/sckb_back.sv =====
// Pixel expander: walks each queued block x outer, y inner, one write per cycle
// into an output register while it is free or popped. Depends on sckb_pkg and the assertion macros.
`include "scaled_color_key_sprite_blit_top_assert.svh"
module sckb_back
  import sckb_pkg::*;
#(
  parameter int MAX_SCALE = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  sckb_job_t          q_data,
  output logic               q_pop,
  input  logic               out_pop,
  output logic               out_empty,
  output logic [PIX_W-1:0]   out_x,
  output logic [PIX_W-1:0]   out_y,
  output logic [COLOR_W-1:0] out_color,
  output logic               out_last
);

  localparam int CNT_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

  sckb_job_t          cur_r, cur_nxt;
  logic               cur_valid_r, cur_valid_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt, j_r, j_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]   px_r, px_nxt, py_r, py_nxt;
  logic [COLOR_W-1:0] pc_r, pc_nxt;
  logic               pl_r, pl_nxt;
  logic               adv, j_end, last_pix;

  always_comb begin
    j_end    = SCALE_W'(j_r) == cur_r.s - 4'd1;
    last_pix = j_end && (SCALE_W'(i_r) == cur_r.s - 4'd1);
    adv      = cur_valid_r && (!out_valid_r || out_pop);
    q_pop    = q_valid && (!cur_valid_r || (adv && last_pix));

    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    pc_nxt        = pc_r;
    pl_nxt        = pl_r;

    if (adv) begin
      out_valid_nxt = 1'b1;
      px_nxt        = cur_r.bx + PIX_W'(i_r);
      py_nxt        = cur_r.by + PIX_W'(j_r);
      pc_nxt        = cur_r.color;
      pl_nxt        = last_pix;
      if (j_end) begin
        j_nxt = '0;
        i_nxt = i_r + 1'b1;
      end else begin
        j_nxt = j_r + 1'b1;
      end
      if (last_pix) begin
        cur_valid_nxt = 1'b0;
      end
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end

    if (q_pop) begin
      cur_nxt       = q_data;
      cur_valid_nxt = 1'b1;
      i_nxt         = '0;
      j_nxt         = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    pc_r  <= pc_nxt;
    pl_r  <= pl_nxt;
  end

  assign out_empty = !out_valid_r;
  assign out_x     = px_r;
  assign out_y     = py_r;
  assign out_color = pc_r;
  assign out_last  = pl_r;

  `SCKB_ASSERT_IMPLIES(a_count_in_block,
    cur_valid_r, (SCALE_W'(i_r) < cur_r.s) && (SCALE_W'(j_r) < cur_r.s))
  `SCKB_ASSERT_NEXT(a_last_marked, adv && last_pix, out_valid_r && pl_r)

endmodule

// ===== src/scaled_color_key_sprite_blit_top.sv =====
// Scaled color key sprite blitter, top level: config registers, front end,
// job queue and pixel expander. Depends on sckb_pkg and the sckb_* modules.
// The first write of a visible texel passes the job queue, the expander's block
// register and the output register. The expander emits one write per cycle when
// not stalled, scale*scale per texel; keyed or clipped texels end at the front end.
// Reset (synchronous, rst_n low): config to reset values, queue and outputs empty.
module scaled_color_key_sprite_blit_top
  import sckb_pkg::*;
#(
  parameter int MAX_BITMAP_SIDE = 1024,
  parameter int MAX_SCALE       = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [COL_W-1:0]        in_texel_col,
  input  logic [COL_W-1:0]        in_texel_row,
  input  logic [COLOR_W-1:0]      in_texel_color,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic signed [PIX_W-1:0] out_pixel_x,
  output logic signed [PIX_W-1:0] out_pixel_y,
  output logic [COLOR_W-1:0]      out_pixel_color,
  output logic                    out_last_of_block
);

  sckb_cfg_t cfg_r, cfg_nxt;
  logic      q_full, q_push, q_valid, q_pop;
  sckb_job_t q_wdata, q_rdata;
  logic [PIX_W-1:0] px, py;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:    cfg_nxt.origin_x    = cfg_wdata;
        REG_ORIGIN_Y:    cfg_nxt.origin_y    = cfg_wdata;
        REG_CLIP_LEFT:   cfg_nxt.clip_left   = cfg_wdata;
        REG_CLIP_TOP:    cfg_nxt.clip_top    = cfg_wdata;
        REG_CLIP_RIGHT:  cfg_nxt.clip_right  = cfg_wdata;
        REG_CLIP_BOTTOM: cfg_nxt.clip_bottom = cfg_wdata;
        REG_SCALE:       cfg_nxt.scale       = cfg_wdata[SCALE_W-1:0];
        REG_KEY_COLOR:   cfg_nxt.key_color   = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x    <= '0;
      cfg_r.origin_y    <= '0;
      cfg_r.clip_left   <= '0;
      cfg_r.clip_top    <= '0;
      cfg_r.clip_right  <= '0;
      cfg_r.clip_bottom <= '0;
      cfg_r.scale       <= SCALE_RESET;
      cfg_r.key_color   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sckb_front #(
    .MAX_BITMAP_SIDE(MAX_BITMAP_SIDE),
    .MAX_SCALE      (MAX_SCALE)
  ) u_front (
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_col  (in_texel_col),
    .in_row  (in_texel_row),
    .in_color(in_texel_color),
    .q_full  (q_full),
    .in_full (in_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  sckb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .pop_data (q_rdata)
  );

  sckb_back #(
    .MAX_SCALE(MAX_SCALE)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_x    (px),
    .out_y    (py),
    .out_color(out_pixel_color),
    .out_last (out_last_of_block)
  );

  assign out_pixel_x = $signed(px);
  assign out_pixel_y = $signed(py);

endmodule

// ===== sim/sckb_blit_checker.sv =====
// Checker for the scaled color key sprite blitter: tracks register writes, expands each
// accepted texel request into its expected pixel writes and compares them in order.
// Depends on sckb_pkg.
module sckb_blit_checker
  import sckb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_push,
  input  logic                    in_full,
  input  logic [COL_W-1:0]        in_texel_col,
  input  logic [COL_W-1:0]        in_texel_row,
  input  logic [COLOR_W-1:0]      in_texel_color,
  input  logic                    out_empty,
  input  logic                    out_pop,
  input  logic signed [PIX_W-1:0] out_pixel_x,
  input  logic signed [PIX_W-1:0] out_pixel_y,
  input  logic [COLOR_W-1:0]      out_pixel_color,
  input  logic                    out_last_of_block,
  output int                      mismatch_count,
  output int                      writes_pending
);

  localparam int BLIT_MAX_SCALE = 8;

  typedef struct packed {
    logic [PIX_W-1:0]   x;
    logic [PIX_W-1:0]   y;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_write_t;

  pixel_write_t expected_writes[$];
  pixel_write_t got;
  pixel_write_t want;
  sckb_cfg_t    regs;
  int           mismatches;

  function automatic void expand_texel(input logic [COL_W-1:0] col,
                                       input logic [COL_W-1:0] row,
                                       input logic [COLOR_W-1:0] color);
    int s;
    int bx;
    int by;
    pixel_write_t w;
    s = (int'(regs.scale) > BLIT_MAX_SCALE) ? BLIT_MAX_SCALE : int'(regs.scale);
    if (s == 0 || color == regs.key_color) return;
    bx = int'($signed(regs.origin_x)) + int'(col) * s;
    by = int'($signed(regs.origin_y)) + int'(row) * s;
    if (bx >= int'($signed(regs.clip_right)) || bx + s <= int'($signed(regs.clip_left)))
      return;
    if (by >= int'($signed(regs.clip_bottom)) || by + s <= int'($signed(regs.clip_top)))
      return;
    for (int i = 0; i < s; i++) begin
      for (int j = 0; j < s; j++) begin
        w.x     = PIX_W'(bx + i);
        w.y     = PIX_W'(by + j);
        w.color = color;
        w.last  = (i == s - 1) && (j == s - 1);
        expected_writes.push_back(w);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs = '0;
      regs.scale = SCALE_RESET;
      expected_writes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ORIGIN_X:    regs.origin_x    = cfg_wdata;
          REG_ORIGIN_Y:    regs.origin_y    = cfg_wdata;
          REG_CLIP_LEFT:   regs.clip_left   = cfg_wdata;
          REG_CLIP_TOP:    regs.clip_top    = cfg_wdata;
          REG_CLIP_RIGHT:  regs.clip_right  = cfg_wdata;
          REG_CLIP_BOTTOM: regs.clip_bottom = cfg_wdata;
          REG_SCALE:       regs.scale       = cfg_wdata[SCALE_W-1:0];
          REG_KEY_COLOR:   regs.key_color   = cfg_wdata;
          default: ;
        endcase
      end
      if (in_push && !in_full)
        expand_texel(in_texel_col, in_texel_row, in_texel_color);
      if (out_pop && !out_empty) begin
        got = '{out_pixel_x, out_pixel_y, out_pixel_color, out_last_of_block};
        if (expected_writes.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected pixel write: expected none, got x=%0d y=%0d color=%h last=%b",
                   $time, $signed(got.x), $signed(got.y), got.color, got.last);
        end else begin
          want = expected_writes.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: pixel write mismatch: expected x=%0d y=%0d color=%h last=%b",
                     $time, $signed(want.x), $signed(want.y), want.color, want.last);
            $display("%0t:                       actual   x=%0d y=%0d color=%h last=%b",
                     $time, $signed(got.x), $signed(got.y), got.color, got.last);
          end
        end
      end
    end
    writes_pending <= expected_writes.size();
    mismatch_count <= mismatches;
  end

endmodule

// ===== sim/scaled_color_key_sprite_blit_top_tb.sv =====
// Testbench top for the scaled color key sprite blitter: drives register setups and
// texel requests with random stalls, and gives the verdict from sckb_blit_checker.
// Depends on sckb_pkg, sckb_blit_checker and scaled_color_key_sprite_blit_top.
module scaled_color_key_sprite_blit_top_tb;
  import sckb_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int PHASE_ITEMS   = 31;
  localparam int RANDOM_PHASES = 10;
  localparam int SETTLE_CYCLES = 6;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;
  logic                    in_push;
  logic                    in_full;
  logic [COL_W-1:0]        in_texel_col;
  logic [COL_W-1:0]        in_texel_row;
  logic [COLOR_W-1:0]      in_texel_color;
  logic                    out_empty;
  logic                    out_pop;
  logic signed [PIX_W-1:0] out_pixel_x;
  logic signed [PIX_W-1:0] out_pixel_y;
  logic [COLOR_W-1:0]      out_pixel_color;
  logic                    out_last_of_block;

  int fail_total;
  int writes_pending;
  int cycle_count;
  int hold_left;
  bit idle_on;

  scaled_color_key_sprite_blit_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_texel_col      (in_texel_col),
    .in_texel_row      (in_texel_row),
    .in_texel_color    (in_texel_color),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_color   (out_pixel_color),
    .out_last_of_block (out_last_of_block)
  );

  sckb_blit_checker i_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_texel_col      (in_texel_col),
    .in_texel_row      (in_texel_row),
    .in_texel_color    (in_texel_color),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_color   (out_pixel_color),
    .out_last_of_block (out_last_of_block),
    .mismatch_count    (fail_total),
    .writes_pending    (writes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("scaled_color_key_sprite_blit_top regression: fail");
      $finish;
    end
  end

  // consumer side: random hold bursts while idle_on is set
  initial begin
    out_pop <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 11) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  function automatic sckb_cfg_t make_setup(input int ox, input int oy, input int cl,
                                           input int ct, input int cr, input int cb,
                                           input int sc, input int key);
    sckb_cfg_t c;
    c.origin_x    = COORD_W'(ox);
    c.origin_y    = COORD_W'(oy);
    c.clip_left   = COORD_W'(cl);
    c.clip_top    = COORD_W'(ct);
    c.clip_right  = COORD_W'(cr);
    c.clip_bottom = COORD_W'(cb);
    c.scale       = SCALE_W'(sc);
    c.key_color   = COLOR_W'(key);
    return c;
  endfunction

  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (writes_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_regs(input sckb_cfg_t c);
    logic [CFG_DATA_W-1:0] vals [8];
    settle();
    vals[REG_ORIGIN_X]    = c.origin_x;
    vals[REG_ORIGIN_Y]    = c.origin_y;
    vals[REG_CLIP_LEFT]   = c.clip_left;
    vals[REG_CLIP_TOP]    = c.clip_top;
    vals[REG_CLIP_RIGHT]  = c.clip_right;
    vals[REG_CLIP_BOTTOM] = c.clip_bottom;
    vals[REG_SCALE]       = CFG_DATA_W'($urandom());
    vals[REG_SCALE][SCALE_W-1:0] = c.scale;
    vals[REG_KEY_COLOR]   = c.key_color;
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_texel(input logic [COL_W-1:0] col, input logic [COL_W-1:0] row,
                            input logic [COLOR_W-1:0] color);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_push        <= 1'b1;
    in_texel_col   <= col;
    in_texel_row   <= row;
    in_texel_color <= color;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  initial begin
    sckb_cfg_t          setup;
    int                 cl;
    int                 ct;
    int                 sc;
    int                 pick;
    logic [COL_W-1:0]   col;
    logic [COL_W-1:0]   row;
    logic [COLOR_W-1:0] color;

    cycle_count = 0;
    idle_on = 1'b1;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    in_push        <= 1'b0;
    in_texel_col   <= '0;
    in_texel_row   <= '0;
    in_texel_color <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setup: empty clip rectangle, key color zero
    send_texel(10'd0, 10'd0, 16'h0001);
    send_texel(10'd3, 10'd2, 16'hFFFF);
    send_texel(10'd0, 10'd0, 16'h0000);

    load_regs(make_setup(0, 0, 0, 0, 1024, 1024, 1, 16'h0000));
    send_texel(10'd0, 10'd0, 16'h0000);
    send_texel(10'd0, 10'd0, 16'hFFFF);
    send_texel(10'd1023, 10'd1023, 16'h0001);
    send_texel(10'd5, 10'd7, 16'hF800);

    load_regs(make_setup(-32768, -32768, -32768, -32768, 32767, 32767, 8, 16'hFFFF));
    send_texel(10'd0, 10'd0, 16'hFFFF);
    send_texel(10'd0, 10'd0, 16'h0000);
    send_texel(10'd1023, 10'd1023, 16'h07E0);
    send_texel(10'd1023, 10'd0, 16'h001F);

    // saturated scale; block runs past the clip edge
    load_regs(make_setup(32766, 32766, 32760, 32760, 32767, 32767, 15, 16'h1234));
    send_texel(10'd0, 10'd0, 16'h5555);
    send_texel(10'd1, 10'd0, 16'h5555);
    send_texel(10'd0, 10'd1, 16'h1234);

    load_regs(make_setup(0, 0, 10, 10, 11, 11, 4, 16'h0000));
    send_texel(10'd2, 10'd2, 16'hAAAA);
    send_texel(10'd3, 10'd2, 16'hAAAA);
    send_texel(10'd2, 10'd3, 16'hAAAA);

    // inverted and zero-height clip rectangle
    load_regs(make_setup(0, 0, 100, 64, 50, 64, 2, 16'h0000));
    send_texel(10'd60, 10'd32, 16'h1111);
    send_texel(10'd0, 10'd0, 16'h2222);

    load_regs(make_setup(0, 0, 0, 0, 1024, 1024, 0, 16'h0000));
    send_texel(10'd1, 10'd1, 16'h3333);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_on = (p < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick == 0)      sc = $urandom_range(0, 15);
      else if (pick < 3)  sc = $urandom_range(5, 8);
      else                sc = $urandom_range(1, 4);
      if ($urandom_range(0, 3) == 0) begin
        setup = make_setup($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom(), sc, $urandom());
      end else begin
        cl = int'($urandom_range(0, 40)) - 10;
        ct = int'($urandom_range(0, 40)) - 10;
        setup = make_setup(int'($urandom_range(0, 40)) - 20, int'($urandom_range(0, 40)) - 20,
                           cl, ct, cl + int'($urandom_range(0, 60)),
                           ct + int'($urandom_range(0, 60)), sc, $urandom());
      end
      load_regs(setup);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          col = COL_W'($urandom());
          row = COL_W'($urandom());
        end else begin
          col = COL_W'($urandom_range(0, 24));
          row = COL_W'($urandom_range(0, 24));
        end
        color = ($urandom_range(0, 4) == 0) ? setup.key_color : COLOR_W'($urandom());
        send_texel(col, row, color);
      end
    end

    settle();
    if (fail_total == 0)
      $display("scaled_color_key_sprite_blit_top regression: pass");
    else
      $display("scaled_color_key_sprite_blit_top regression: fail");
    $finish;
  end

endmodule
